[hdl/glos_pkg.sv]
// glos_pkg: shared types, constants and codes for the grid line-of-sight block
// no dependencies; compiled first
`timescale 1ns / 1ps

package glos_pkg;

   // default grid edge length, cells per row and per column
   localparam int GLOS_GRID_SIZE = 16;

   // fixed field widths
   localparam int COORD_W    = 4;
   localparam int DIST_W     = 5;
   localparam int PROD_W     = 9;   // holds (1 + 2*15) * 15
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // register reset values
   localparam logic [DIST_W-1:0] MAX_RANGE_RST = 5'd30;
   localparam logic [DIST_W-1:0] MIN_RANGE_RST = 5'd0;

   // item opcodes
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RANGE = 1'b0,
      CSR_MIN_RANGE = 1'b1
   } csr_idx_type;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_OUT
   } glos_state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_en;      // write one zero entry of the clearing pass
      logic wr_en;       // write beat accepted
      logic load_query;  // query beat accepted, set up the walk
      logic step;        // advance the walk and read the entered cell
      logic finish;      // capture the visibility verdict
      logic load_rsp;    // move the verdict into the output register
   } glos_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;    // clearing pass is at the last entry
      logic more;        // cells remain on the walk
      logic pend;        // a map read is in flight
      logic hit;         // the cell read back is blocked
      logic reject;      // query out of grid or out of range
      logic rsp_free;    // output register can take a beat
   } glos_sts_type;

endpackage

[hdl/glos_if.sv]
// glos_if: valid/ready channels for requests, responses and register writes
// depends on glos_pkg for field widths
`timescale 1ns / 1ps

interface glos_req_if;
   import glos_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [COORD_W-1:0]   cell_x;
   logic [COORD_W-1:0]   cell_y;
   logic                 blocked_value;
   logic [COORD_W-1:0]   source_x;
   logic [COORD_W-1:0]   source_y;

   modport source (output valid, opcode, cell_x, cell_y, blocked_value, source_x, source_y,
                   input ready);
   modport sink   (input valid, opcode, cell_x, cell_y, blocked_value, source_x, source_y,
                   output ready);
endinterface

interface glos_rsp_if;
   import glos_pkg::*;
   logic                valid;
   logic                ready;
   logic                visible;
   logic [DIST_W-1:0]   distance;

   modport source (output valid, visible, distance, input ready);
   modport sink   (input valid, visible, distance, output ready);
endinterface

interface glos_csr_if;
   import glos_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    index;
   logic [CSR_DATA_W-1:0]   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[hdl/glos_ctrl.sv]
// glos_ctrl: state machine sequencing clear, write, walk and response
// depends on glos_pkg for state, command and status types
`timescale 1ns / 1ps

module glos_ctrl import glos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  op_type        req_opcode,
   output logic          req_ready,
   input  glos_sts_type  sts,
   output glos_cmd_type  cmd
);

   glos_state_type state_ff;
   glos_state_type state_in;
   logic           walk_done;

   // walk ends on reject, on a blocked cell, or once the last read is checked
   assign walk_done = sts.reject || sts.hit || (!sts.more && !sts.pend);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_QUERY) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.wr_en      = req_valid && req_opcode == OP_WRITE;
            cmd.load_query = req_valid && req_opcode == OP_QUERY;
         end
         ST_WALK: begin
            cmd.step   = !walk_done && sts.more;
            cmd.finish = walk_done;
         end
         ST_OUT: begin
            cmd.load_rsp = sts.rsp_free;
         end
      endcase
   end

endmodule

[hdl/glos_dpath.sv]
// glos_dpath: blocked-cell map, range registers, walk counters and output register
// depends on glos_pkg for widths, codes and command/status types
`timescale 1ns / 1ps

module glos_dpath import glos_pkg::*;
#(
   parameter int GRID_SIZE = GLOS_GRID_SIZE
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  glos_cmd_type            cmd,
   output glos_sts_type            sts,
   input  logic [COORD_W-1:0]      cell_x,
   input  logic [COORD_W-1:0]      cell_y,
   input  logic                    blocked_value,
   input  logic [COORD_W-1:0]      source_x,
   input  logic [COORD_W-1:0]      source_y,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    visible,
   output logic [DIST_W-1:0]       distance
);

   localparam int              DEPTH      = GRID_SIZE * GRID_SIZE;
   localparam int              AW         = $clog2(DEPTH);
   localparam logic [AW-1:0]   LAST_ADDR  = AW'(DEPTH - 1);
   localparam logic [AW-1:0]   ROW_STRIDE = AW'(GRID_SIZE);

   // map memory and its ports
   logic                mem_ff [DEPTH];
   logic                rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic                mem_wdata;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;

   // range registers
   logic [DIST_W-1:0]   max_range_ff, max_range_in;
   logic [DIST_W-1:0]   min_range_ff, min_range_in;

   // query setup
   logic                tgt_in_grid, src_in_grid;
   logic                xpos, ypos;
   logic [COORD_W-1:0]  nx, ny;
   logic [DIST_W-1:0]   manh_dist;
   logic                rejected;

   // walk registers
   logic [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [COORD_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [COORD_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [PROD_W-1:0]   lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic                xpos_ff, xpos_in, ypos_ff, ypos_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic                reject_ff, reject_in;
   logic                pend_ff, pend_in;
   logic                vis_ff, vis_in;

   // step logic
   logic                diag, go_x, adv_i, adv_j, hit;
   logic [COORD_W-1:0]  px_nx, py_nx;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                visible_ff;
   logic [DIST_W-1:0]   distance_ff;

   // register writes
   always_comb begin
      max_range_in = max_range_ff;
      min_range_in = min_range_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_RANGE: max_range_in = csr_wdata;
            CSR_MIN_RANGE: min_range_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RST;
         min_range_ff <= MIN_RANGE_RST;
      end else begin
         max_range_ff <= max_range_in;
         min_range_ff <= min_range_in;
      end
   end

   // query setup from the request beat
   always_comb begin
      tgt_in_grid = (int'(cell_x) < GRID_SIZE) && (int'(cell_y) < GRID_SIZE);
      src_in_grid = (int'(source_x) < GRID_SIZE) && (int'(source_y) < GRID_SIZE);
      xpos        = cell_x > source_x;
      ypos        = cell_y > source_y;
      nx          = xpos ? cell_x - source_x : source_x - cell_x;
      ny          = ypos ? cell_y - source_y : source_y - cell_y;
      manh_dist   = {1'b0, nx} + {1'b0, ny};
      rejected    = !tgt_in_grid || !src_in_grid
                    || manh_dist > max_range_ff || manh_dist < min_range_ff;
   end

   // next cell: compare (1+2i)*ny with (1+2j)*nx, kept as running sums
   always_comb begin
      diag  = lhs_ff == rhs_ff;
      go_x  = lhs_ff < rhs_ff;
      adv_i = diag || go_x;
      adv_j = diag || !go_x;
      px_nx = px_ff;
      py_nx = py_ff;
      if (adv_i) px_nx = xpos_ff ? px_ff + 1'b1 : px_ff - 1'b1;
      if (adv_j) py_nx = ypos_ff ? py_ff + 1'b1 : py_ff - 1'b1;
      rd_addr = AW'(px_nx) * ROW_STRIDE + AW'(py_nx);
   end

   // walk register updates
   always_comb begin
      px_in     = px_ff;
      py_in     = py_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      lhs_in    = lhs_ff;
      rhs_in    = rhs_ff;
      xpos_in   = xpos_ff;
      ypos_in   = ypos_ff;
      dist_in   = dist_ff;
      reject_in = reject_ff;
      if (cmd.load_query) begin
         px_in     = source_x;
         py_in     = source_y;
         i_in      = '0;
         j_in      = '0;
         nx_in     = nx;
         ny_in     = ny;
         lhs_in    = PROD_W'(ny);
         rhs_in    = PROD_W'(nx);
         xpos_in   = xpos;
         ypos_in   = ypos;
         dist_in   = manh_dist;
         reject_in = rejected;
      end else if (cmd.step) begin
         px_in = px_nx;
         py_in = py_nx;
         if (adv_i) begin
            i_in   = i_ff + 1'b1;
            lhs_in = lhs_ff + PROD_W'({ny_ff, 1'b0});
         end
         if (adv_j) begin
            j_in   = j_ff + 1'b1;
            rhs_in = rhs_ff + PROD_W'({nx_ff, 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
      xpos_ff   <= xpos_in;
      ypos_ff   <= ypos_in;
      dist_ff   <= dist_in;
      reject_ff <= reject_in;
   end

   // map write port: clearing pass or write beat inside the grid
   always_comb begin
      clr_addr_in = cmd.clr_en ? clr_addr_ff + 1'b1 : clr_addr_ff;
      mem_we      = cmd.clr_en || (cmd.wr_en && tgt_in_grid);
      mem_waddr   = cmd.clr_en ? clr_addr_ff : AW'(cell_x) * ROW_STRIDE + AW'(cell_y);
      mem_wdata   = cmd.clr_en ? 1'b0 : blocked_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // map memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      if (cmd.step) rd_data_ff <= mem_ff[rd_addr];
   end

   // read in flight and verdict
   assign pend_in = cmd.step;
   assign hit     = pend_ff && rd_data_ff;
   assign vis_in  = cmd.finish ? (!reject_ff && !hit) : vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      vis_ff <= vis_in;
   end

   // output register: holds a beat until taken
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         visible_ff  <= vis_ff;
         distance_ff <= vis_ff ? dist_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign visible   = visible_ff;
   assign distance  = distance_ff;

   // status to controller
   always_comb begin
      sts          = '0;
      sts.clr_last = clr_addr_ff == LAST_ADDR;
      sts.more     = (i_ff != nx_ff) || (j_ff != ny_ff);
      sts.pend     = pend_ff;
      sts.hit      = hit;
      sts.reject   = reject_ff;
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

[hdl/grid_line_of_sight.sv]
// Grid line-of-sight block. After reset the block clears its GRID_SIZE x GRID_SIZE
// map of blocked bits in a pass over every entry and takes no request beat until
// that pass ends; register writes are taken at any time. A write beat stores one
// cell's blocked bit if the cell lies inside the grid and gives no response. A query
// beat walks from source to target through the map, one map read per cycle over its
// single read port, and stops at the first blocked cell; the cells it enters are at
// most its Manhattan distance (up to 30 at the default size). A query out of grid or
// out of range reads no map cell, and a stalled response holds the block until the
// output register is free. One query is worked on at a time; a finished response
// waits in an output register while the next request beat is taken.
// Depends on glos_pkg, glos_if, glos_ctrl and glos_dpath.
`timescale 1ns / 1ps

module grid_line_of_sight import glos_pkg::*;
#(
   parameter int GRID_SIZE = GLOS_GRID_SIZE
)
(
   input  logic          clock,
   input  logic          reset,
   glos_req_if.sink      req_chan,
   glos_rsp_if.source    rsp_chan,
   glos_csr_if.sink      csr_chan
);

   glos_cmd_type cmd;
   glos_sts_type sts;

   // register port never stalls
   assign csr_chan.ready = 1'b1;

   // controller
   glos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (op_type'(req_chan.opcode)),
      .req_ready  (req_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   glos_dpath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .cell_x        (req_chan.cell_x),
      .cell_y        (req_chan.cell_y),
      .blocked_value (req_chan.blocked_value),
      .source_x      (req_chan.source_x),
      .source_y      (req_chan.source_y),
      .csr_we        (csr_chan.valid && csr_chan.ready),
      .csr_index     (csr_chan.index),
      .csr_wdata     (csr_chan.wdata),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .visible       (rsp_chan.visible),
      .distance      (rsp_chan.distance)
   );

   // a rejected query never reads the map
   a_no_step_on_reject: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.reject)
      else $error("walk step on a rejected query");

   // a held response is never overwritten
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("response loaded over a held beat");

   // every step leaves a read in flight for the next cycle
   a_step_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> sts.pend)
      else $error("map read lost after a step");

   // no request beat is taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !req_chan.ready)
      else $error("request taken while the map is being cleared");

endmodule
